// ----- sv/agbd_pkg.sv -----
// Anchor grid box decode: shared widths, register map and reset values.
// Standalone package, no dependencies; used by anchor_grid_box_decode_core.
package agbd_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_GRID_DIM_DEF   = 64;
  localparam int PROB_FRAC_BITS_DEF = 16;

  // Payload widths
  localparam int FIELD_W    = 17;
  localparam int BOX_POS_W  = 20;
  localparam int BOX_SIZE_W = 14;
  localparam int STRIDE_W   = 7;
  localparam int DIM_W      = 7;
  localparam int ANCHOR_W   = 8;

  // Configuration port
  localparam int APB_AW = 5;
  localparam int APB_DW = 32;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_THRESHOLD = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_STRIDE    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_COLS      = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ROWS      = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_ANCHOR_W  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_ANCHOR_H  = 3'd5;

  localparam logic [FIELD_W-1:0]  THRESHOLD_RST = 17'd32768;
  localparam logic [STRIDE_W-1:0] STRIDE_RST    = 7'd16;
  localparam logic [DIM_W-1:0]    COLS_RST      = 7'd16;
  localparam logic [DIM_W-1:0]    ROWS_RST      = 7'd12;
  localparam logic [ANCHOR_W-1:0] ANCHOR_W_RST  = 8'd33;
  localparam logic [ANCHOR_W-1:0] ANCHOR_H_RST  = 8'd30;

  localparam logic [FIELD_W-1:0]    SCORE_MAX = 17'h1ffff;
  localparam logic [BOX_SIZE_W-1:0] SIZE_MAX  = 14'h3fff;

endpackage

// ----- sv/anchor_grid_box_decode_core.sv -----
// Anchor grid box decode core: scores, class pick and box decode of one grid cell.
// Depends on agbd_pkg. One shared 25x17 multiplier under a step sequencer.
//
//  channel | handshake                 | payload
//  --------+---------------------------+------------------------------------------
//  in      | in_valid_i / in_ready_o   | obj_prob, left/right_prob, off_x/y, size_w/h
//  out     | out_valid_o / out_ready_i | detected, hand, scores, box_x/y/w/h, last_cell
//  cfg     | psel/penable/pwrite       | paddr, pwdata, prdata, pready (always high)
//
// Each cell passes through the transfer and 11 sequencer steps, ten of them
// multiplies on the single shared multiplier, the last one the edge and output write.
// in_ready_o is high only while the sequencer is idle. A finished result waits in the
// output register; the next cell is taken meanwhile and its final step holds until
// the waiting result has been transferred.
// Reset (rst_ni low, asynchronous) restores the register defaults and clears the
// column and row counters.
module anchor_grid_box_decode_core #(
  parameter int MAX_GRID_DIM   = agbd_pkg::MAX_GRID_DIM_DEF,
  parameter int PROB_FRAC_BITS = agbd_pkg::PROB_FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input cell
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [agbd_pkg::FIELD_W-1:0]        obj_prob_i,
  input  logic [agbd_pkg::FIELD_W-1:0]        left_prob_i,
  input  logic [agbd_pkg::FIELD_W-1:0]        right_prob_i,
  input  logic [agbd_pkg::FIELD_W-1:0]        off_x_i,
  input  logic [agbd_pkg::FIELD_W-1:0]        off_y_i,
  input  logic [agbd_pkg::FIELD_W-1:0]        size_w_i,
  input  logic [agbd_pkg::FIELD_W-1:0]        size_h_i,
  // result
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                detected_o,
  output logic                                hand_is_left_o,
  output logic [agbd_pkg::FIELD_W-1:0]        hand_score_o,
  output logic [agbd_pkg::FIELD_W-1:0]        left_conf_o,
  output logic [agbd_pkg::FIELD_W-1:0]        right_conf_o,
  output logic signed [agbd_pkg::BOX_POS_W-1:0] box_x_o,
  output logic signed [agbd_pkg::BOX_POS_W-1:0] box_y_o,
  output logic [agbd_pkg::BOX_SIZE_W-1:0]     box_w_o,
  output logic [agbd_pkg::BOX_SIZE_W-1:0]     box_h_o,
  output logic                                last_cell_o,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [agbd_pkg::APB_AW-1:0]         paddr,
  input  logic [agbd_pkg::APB_DW-1:0]         pwdata,
  output logic [agbd_pkg::APB_DW-1:0]         prdata,
  output logic                                pready
);

  localparam int FW   = agbd_pkg::FIELD_W;
  localparam int CW   = $clog2(MAX_GRID_DIM);
  localparam int DW   = CW + 1;
  localparam int MA_W = FW + agbd_pkg::ANCHOR_W;   // size factor times anchor
  localparam int MB_W = FW;
  localparam int PW   = MA_W + MB_W;
  localparam int RW   = PW + 1;                    // product plus rounding carry
  localparam int SZ_SHIFT = 2 * PROB_FRAC_BITS - 6;
  localparam int SZ_W = RW - SZ_SHIFT;
  localparam int EW   = PW + 10;                   // signed edge arithmetic
  localparam int PO_W = agbd_pkg::BOX_POS_W;

  // Sequencer states and steps
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  localparam logic [3:0] S_LW  = 4'd0;   // left prob * obj
  localparam logic [3:0] S_RW  = 4'd1;   // right prob * obj
  localparam logic [3:0] S_WA  = 4'd2;   // size_w * anchor_w
  localparam logic [3:0] S_WS  = 4'd3;   // ... * size_w
  localparam logic [3:0] S_HA  = 4'd4;   // size_h * anchor_h
  localparam logic [3:0] S_HS  = 4'd5;   // ... * size_h
  localparam logic [3:0] S_CX  = 4'd6;   // off_x * stride
  localparam logic [3:0] S_PX  = 4'd7;   // col * stride
  localparam logic [3:0] S_CY  = 4'd8;   // off_y * stride, x edge
  localparam logic [3:0] S_PY  = 4'd9;   // row * stride
  localparam logic [3:0] S_FIN = 4'd10;  // y edge, result write

  // Configuration registers
  logic [FW-1:0]                       thr_q;
  logic [agbd_pkg::STRIDE_W-1:0]       stride_q;
  logic [agbd_pkg::DIM_W-1:0]          cols_q;
  logic [agbd_pkg::DIM_W-1:0]          rows_q;
  logic [agbd_pkg::ANCHOR_W-1:0]       anc_w_q;
  logic [agbd_pkg::ANCHOR_W-1:0]       anc_h_q;
  logic                                cfg_wr;
  logic [agbd_pkg::REG_IDX_W-1:0]      cfg_idx;

  // Control
  logic                                state_q;
  logic [3:0]                          step_q;
  logic                                in_fire;
  logic                                out_free;
  logic [CW-1:0]                       col_q;
  logic [CW-1:0]                       row_q;
  logic [DW-1:0]                       cols_c;
  logic [DW-1:0]                       rows_c;
  logic                                end_col;
  logic                                end_row;

  // Captured cell
  logic [FW-1:0]                       obj_q, lp_q, rp_q, ox_q, oy_q, sw_q, sh_q;
  logic [CW-1:0]                       cell_col_q;
  logic [CW-1:0]                       cell_row_q;
  logic                                cell_last_q;

  // Datapath
  logic [MA_W-1:0]                     mul_a;
  logic [MB_W-1:0]                     mul_b;
  logic [PW-1:0]                       prod_q;
  logic [PW-1:0]                       wt_shift;
  logic [FW-1:0]                       wt_sat;
  logic [RW-1:0]                       sz_sum;
  logic [SZ_W-1:0]                     sz_round;
  logic [EW-1:0]                       c_sum;
  logic [EW-1:0]                       c_pos;
  logic [FW-1:0]                       lw_q, rw_q;
  logic [SZ_W-1:0]                     w16_q, h16_q;
  logic [EW-1:0]                       cpos_q;
  logic signed [EW-1:0]                edge_v32;
  logic signed [EW-1:0]                edge_v16;
  logic [SZ_W-1:0]                     edge_size;
  logic [PO_W-1:0]                     edge_sat;
  logic [PO_W-1:0]                     bx_q;
  logic                                is_left;
  logic [FW-1:0]                       score;

  // Output register
  logic                                out_valid_q;
  logic                                det_q, left_q, last_q;
  logic [FW-1:0]                       score_q, lconf_q, rconf_q;
  logic [PO_W-1:0]                     box_x_q, box_y_q;
  logic [agbd_pkg::BOX_SIZE_W-1:0]     box_w_q, box_h_q;

  // ---------------------------------------------------------------- config port
  assign pready  = 1'b1;
  assign cfg_idx = paddr[agbd_pkg::APB_AW-1:2];
  assign cfg_wr  = psel & penable & pwrite;

  always_comb begin
    prdata = '0;
    case (cfg_idx)
      agbd_pkg::REG_THRESHOLD: prdata = agbd_pkg::APB_DW'(thr_q);
      agbd_pkg::REG_STRIDE:    prdata = agbd_pkg::APB_DW'(stride_q);
      agbd_pkg::REG_COLS:      prdata = agbd_pkg::APB_DW'(cols_q);
      agbd_pkg::REG_ROWS:      prdata = agbd_pkg::APB_DW'(rows_q);
      agbd_pkg::REG_ANCHOR_W:  prdata = agbd_pkg::APB_DW'(anc_w_q);
      agbd_pkg::REG_ANCHOR_H:  prdata = agbd_pkg::APB_DW'(anc_h_q);
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= agbd_pkg::THRESHOLD_RST;
      stride_q <= agbd_pkg::STRIDE_RST;
      cols_q   <= agbd_pkg::COLS_RST;
      rows_q   <= agbd_pkg::ROWS_RST;
      anc_w_q  <= agbd_pkg::ANCHOR_W_RST;
      anc_h_q  <= agbd_pkg::ANCHOR_H_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        agbd_pkg::REG_THRESHOLD: thr_q    <= pwdata[FW-1:0];
        agbd_pkg::REG_STRIDE:    stride_q <= pwdata[agbd_pkg::STRIDE_W-1:0];
        agbd_pkg::REG_COLS:      cols_q   <= pwdata[agbd_pkg::DIM_W-1:0];
        agbd_pkg::REG_ROWS:      rows_q   <= pwdata[agbd_pkg::DIM_W-1:0];
        agbd_pkg::REG_ANCHOR_W:  anc_w_q  <= pwdata[agbd_pkg::ANCHOR_W-1:0];
        agbd_pkg::REG_ANCHOR_H:  anc_h_q  <= pwdata[agbd_pkg::ANCHOR_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- grid position
  // Clamp the grid size to 1..MAX_GRID_DIM; a value above the limit is never picked
  // through the narrowing cast.
  always_comb begin
    if (cols_q == '0)
      cols_c = DW'(1);
    else if (32'(cols_q) > 32'(MAX_GRID_DIM))
      cols_c = DW'(MAX_GRID_DIM);
    else
      cols_c = DW'(cols_q);
    if (rows_q == '0)
      rows_c = DW'(1);
    else if (32'(rows_q) > 32'(MAX_GRID_DIM))
      rows_c = DW'(MAX_GRID_DIM);
    else
      rows_c = DW'(rows_q);
  end

  assign end_col = ({1'b0, col_q} + DW'(1)) >= cols_c;
  assign end_row = ({1'b0, row_q} + DW'(1)) >= rows_c;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i & in_ready_o;
  assign out_free   = ~out_valid_q | out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_fire) begin
      if (end_col) begin
        col_q <= '0;
        row_q <= end_row ? '0 : row_q + CW'(1);
      end else begin
        col_q <= col_q + CW'(1);
      end
    end
  end

  // Capture the cell on transfer
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      obj_q       <= obj_prob_i;
      lp_q        <= left_prob_i;
      rp_q        <= right_prob_i;
      ox_q        <= off_x_i;
      oy_q        <= off_y_i;
      sw_q        <= size_w_i;
      sh_q        <= size_h_i;
      cell_col_q  <= col_q;
      cell_row_q  <= row_q;
      cell_last_q <= end_col & end_row;
    end
  end

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= S_LW;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            state_q <= ST_RUN;
            step_q  <= S_LW;
          end
        end
        ST_RUN: begin
          if (step_q == S_FIN) begin
            // hold the final step until the output register is free
            if (out_free) begin
              state_q <= ST_IDLE;
              step_q  <= S_LW;
            end
          end else begin
            step_q <= step_q + 4'd1;
          end
        end
        default: begin
          state_q <= ST_IDLE;
          step_q  <= S_LW;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------- shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (step_q)
      S_LW: begin mul_a = MA_W'(obj_q);          mul_b = lp_q;                  end
      S_RW: begin mul_a = MA_W'(obj_q);          mul_b = rp_q;                  end
      S_WA: begin mul_a = MA_W'(sw_q);           mul_b = MB_W'(anc_w_q);        end
      S_WS: begin mul_a = prod_q[MA_W-1:0];      mul_b = sw_q;                  end
      S_HA: begin mul_a = MA_W'(sh_q);           mul_b = MB_W'(anc_h_q);        end
      S_HS: begin mul_a = prod_q[MA_W-1:0];      mul_b = sh_q;                  end
      S_CX: begin mul_a = MA_W'(ox_q);           mul_b = MB_W'(stride_q);       end
      S_PX: begin mul_a = MA_W'(cell_col_q);     mul_b = MB_W'(stride_q);       end
      S_CY: begin mul_a = MA_W'(oy_q);           mul_b = MB_W'(stride_q);       end
      S_PY: begin mul_a = MA_W'(cell_row_q);     mul_b = MB_W'(stride_q);       end
      default: begin mul_a = '0;                 mul_b = '0;                    end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_RUN && step_q != S_FIN) begin
      prod_q <= PW'(mul_a) * PW'(mul_b);
    end
  end

  // ---------------------------------------------------------------- post-processing
  // Weighted score: truncate the fraction, saturate to the field
  assign wt_shift = prod_q >> PROB_FRAC_BITS;
  assign wt_sat   = (wt_shift > PW'(agbd_pkg::SCORE_MAX)) ? agbd_pkg::SCORE_MAX
                                                          : wt_shift[FW-1:0];

  // Box size in 1/16 px, round half up
  assign sz_sum   = RW'(prod_q) + (RW'(1) << (SZ_SHIFT - 1));
  assign sz_round = SZ_W'(sz_sum >> SZ_SHIFT);

  // Centre offset in 1/32 px from off * stride
  assign c_sum = (EW'(prod_q) << 6) + (EW'(1) << (PROB_FRAC_BITS - 1));
  assign c_pos = c_sum >> PROB_FRAC_BITS;

  // Edge = centre + (32*pos - 16)*stride - size, then halve with floor and saturate
  assign edge_size = (step_q == S_CY) ? w16_q : h16_q;
  assign edge_v32  = $signed(cpos_q)
                   + $signed(EW'(prod_q) << 5)
                   - $signed(EW'(stride_q) << 4)
                   - $signed(EW'(edge_size));
  assign edge_v16  = edge_v32 >>> 1;

  always_comb begin
    if (edge_v16[EW-1:PO_W-1] == '0 || edge_v16[EW-1:PO_W-1] == '1)
      edge_sat = edge_v16[PO_W-1:0];
    else if (edge_v16[EW-1])
      edge_sat = {1'b1, {(PO_W-1){1'b0}}};
    else
      edge_sat = {1'b0, {(PO_W-1){1'b1}}};
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_RUN) begin
      case (step_q)
        S_RW:    lw_q   <= wt_sat;
        S_WA:    rw_q   <= wt_sat;
        S_HA:    w16_q  <= sz_round;
        S_CX:    h16_q  <= sz_round;
        S_PX:    cpos_q <= c_pos;
        S_CY:    bx_q   <= edge_sat;
        S_PY:    cpos_q <= c_pos;
        default: ;
      endcase
    end
  end

  assign is_left = lw_q > rw_q;
  assign score   = is_left ? lw_q : rw_q;

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_RUN && step_q == S_FIN && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_RUN && step_q == S_FIN && out_free) begin
      det_q   <= score > thr_q;
      left_q  <= is_left;
      score_q <= score;
      lconf_q <= lp_q;
      rconf_q <= rp_q;
      box_x_q <= bx_q;
      box_y_q <= edge_sat;
      box_w_q <= (64'(w16_q) > 64'(agbd_pkg::SIZE_MAX)) ? agbd_pkg::SIZE_MAX
                                                        : agbd_pkg::BOX_SIZE_W'(w16_q);
      box_h_q <= (64'(h16_q) > 64'(agbd_pkg::SIZE_MAX)) ? agbd_pkg::SIZE_MAX
                                                        : agbd_pkg::BOX_SIZE_W'(h16_q);
      last_q  <= cell_last_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign detected_o     = det_q;
  assign hand_is_left_o = left_q;
  assign hand_score_o   = score_q;
  assign left_conf_o    = lconf_q;
  assign right_conf_o   = rconf_q;
  assign box_x_o        = $signed(box_x_q);
  assign box_y_o        = $signed(box_y_q);
  assign box_w_o        = box_w_q;
  assign box_h_o        = box_h_q;
  assign last_cell_o    = last_q;

endmodule
